// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
// Each macro expects clk and rst_n in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define OLR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define OLR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define OLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/olr_pkg.sv =====
// ----------------------------------------------------------------------------
// olr_pkg
// Shared widths, request and result codes, and the cell command type of the
// ordered list with value removal.
// ----------------------------------------------------------------------------
package olr_pkg;

  localparam int DataW       = 32;
  localparam int OpW         = 3;
  localparam int StatusW     = 3;
  localparam int CountW      = 5;
  localparam int CapacityDef = 16;

  localparam logic [OpW-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OpW-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OpW-1:0] OP_LIST      = 3'd2;
  localparam logic [OpW-1:0] OP_REMOVE    = 3'd3;
  localparam logic [OpW-1:0] OP_CLEAR     = 3'd4;

  localparam logic [StatusW-1:0] ST_INSERTED = 3'd0;
  localparam logic [StatusW-1:0] ST_DROPPED  = 3'd1;
  localparam logic [StatusW-1:0] ST_ELEMENT  = 3'd2;
  localparam logic [StatusW-1:0] ST_EMPTY    = 3'd3;
  localparam logic [StatusW-1:0] ST_REMOVED  = 3'd4;
  localparam logic [StatusW-1:0] ST_CLEARED  = 3'd5;

  localparam int ModeW = 3;
  localparam logic [ModeW-1:0] M_HOLD = 3'd0;
  localparam logic [ModeW-1:0] M_SHR  = 3'd1;
  localparam logic [ModeW-1:0] M_ROT  = 3'd2;
  localparam logic [ModeW-1:0] M_DROP = 3'd3;
  localparam logic [ModeW-1:0] M_LOAD = 3'd4;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [DataW-1:0] data;
  } cell_cmd_t;

endpackage

// ===== design/olr_if.sv =====
// ----------------------------------------------------------------------------
// olr_in_if / olr_out_if
// Valid/ready channels for requests and results of the ordered list.
// ----------------------------------------------------------------------------
interface olr_in_if;
  logic                                valid;
  logic                                ready;
  logic [olr_pkg::OpW-1:0]             operation;
  logic signed [olr_pkg::DataW-1:0]    value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

interface olr_out_if;
  logic                                valid;
  logic                                ready;
  logic [olr_pkg::StatusW-1:0]         status;
  logic signed [olr_pkg::DataW-1:0]    element;
  logic [olr_pkg::CountW-1:0]          match_count;
  logic                                last;

  modport source (output valid, status, element, match_count, last, input ready);
  modport sink   (input valid, status, element, match_count, last, output ready);
endinterface

// ===== design/ordered_list_with_value_removal_top.sv =====
// ----------------------------------------------------------------------------
// ordered_list_with_value_removal_top
// Bounded ordered list of signed values held in a chain of cells.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (operation, value) and results leave on out_ch
// (status, element, match_count, last); both are valid/ready channels and a
// transfer happens when valid and ready are high at a rising clock edge.
// Insert and clear requests give one result each, registered
// in the output stage in the cycle after the request.
// A list request walks the live cells, one element per cycle while the
// receiver is not stalling, giving occupancy results; the chain rotates
// by one position per result. A remove request compacts the chain, one cell
// examined per cycle, then gives one report.
// A new request is taken only when the previous one has finished its walk
// and the output stage is free or being drained.
// A stalled receiver holds the output stage and freezes a list walk.
// Reset (rst_n low, synchronous) empties the list and the output stage;
// cell contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_list_with_value_removal_top #(
  parameter int CAPACITY = olr_pkg::CapacityDef
) (
  input  logic      clk,
  input  logic      rst_n,
  olr_in_if.sink    in_ch,
  olr_out_if.source out_ch
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LIST   = 2'd1;
  localparam logic [1:0] S_REMOVE = 2'd2;
  localparam logic [1:0] S_REPORT = 2'd3;

  logic [1:0]                       state_r, state_nxt;
  logic [OW-1:0]                    occ_r, occ_nxt;
  logic [OW-1:0]                    steps_r, steps_nxt;
  logic [OW-1:0]                    removed_r, removed_nxt;
  logic [olr_pkg::DataW-1:0]        key_r, key_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [olr_pkg::StatusW-1:0]      out_status_r;
  logic [olr_pkg::DataW-1:0]        out_elem_r;
  logic [olr_pkg::CountW-1:0]       out_count_r;
  logic                             out_last_r;

  logic                             emit;
  logic [olr_pkg::StatusW-1:0]      emit_status;
  logic [olr_pkg::DataW-1:0]        emit_elem;
  logic [olr_pkg::CountW-1:0]       emit_count;
  logic                             emit_last;

  olr_pkg::cell_cmd_t               cmd;
  logic [IW-1:0]                    sel_idx;
  logic [IW-1:0]                    tail_idx;
  logic [CAPACITY-1:0]              sel;
  logic [olr_pkg::DataW-1:0]        cell_val [CAPACITY];
  logic [olr_pkg::DataW-1:0]        front_val;

  logic                             slot_free;
  logic                             in_fire;

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && slot_free;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign front_val   = cell_val[0];
  assign tail_idx    = IW'(occ_r - OW'(1));

  always_comb begin
    state_nxt   = state_r;
    occ_nxt     = occ_r;
    steps_nxt   = steps_r;
    removed_nxt = removed_r;
    key_nxt     = key_r;
    cmd.mode    = olr_pkg::M_HOLD;
    cmd.data    = in_ch.value;
    sel_idx     = tail_idx;
    emit        = 1'b0;
    emit_status = olr_pkg::ST_INSERTED;
    emit_elem   = in_ch.value;
    emit_count  = '0;
    emit_last   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.operation)
            olr_pkg::OP_INS_FRONT, olr_pkg::OP_INS_BACK: begin
              emit = 1'b1;
              if (occ_r == OW'(CAPACITY)) begin
                emit_status = olr_pkg::ST_DROPPED;
              end else begin
                cmd.mode = (in_ch.operation == olr_pkg::OP_INS_FRONT) ?
                           olr_pkg::M_SHR : olr_pkg::M_LOAD;
                sel_idx  = IW'(occ_r);
                occ_nxt  = occ_r + OW'(1);
              end
            end
            olr_pkg::OP_LIST: begin
              if (occ_r == '0) begin
                emit        = 1'b1;
                emit_status = olr_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_LIST;
                steps_nxt = occ_r;
              end
            end
            olr_pkg::OP_REMOVE: begin
              key_nxt     = in_ch.value;
              removed_nxt = '0;
              if (occ_r == '0) begin
                emit        = 1'b1;
                emit_status = olr_pkg::ST_REMOVED;
              end else begin
                state_nxt = S_REMOVE;
                steps_nxt = occ_r;
              end
            end
            olr_pkg::OP_CLEAR: begin
              emit        = 1'b1;
              emit_status = (occ_r == '0) ? olr_pkg::ST_EMPTY : olr_pkg::ST_CLEARED;
              occ_nxt     = '0;
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_status = olr_pkg::ST_ELEMENT;
          emit_elem   = front_val;
          emit_last   = (steps_r == OW'(1));
          cmd.mode    = olr_pkg::M_ROT;
          steps_nxt   = steps_r - OW'(1);
          if (steps_r == OW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_REMOVE: begin
        if (front_val == key_r) begin
          cmd.mode    = olr_pkg::M_DROP;
          occ_nxt     = occ_r - OW'(1);
          removed_nxt = removed_r + OW'(1);
        end else begin
          cmd.mode = olr_pkg::M_ROT;
        end
        steps_nxt = steps_r - OW'(1);
        if (steps_r == OW'(1)) begin
          state_nxt = S_REPORT;
        end
      end
      S_REPORT: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_status = olr_pkg::ST_REMOVED;
          emit_elem   = key_r;
          emit_count  = olr_pkg::CountW'(removed_r);
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = emit ? 1'b1 : (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      steps_r     <= '0;
      removed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      steps_r     <= steps_nxt;
      removed_r   <= removed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (emit) begin
      out_status_r <= emit_status;
      out_elem_r   <= emit_elem;
      out_count_r  <= emit_count;
      out_last_r   <= emit_last;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [olr_pkg::DataW-1:0] left_v;
    logic [olr_pkg::DataW-1:0] right_v;

    assign sel[i] = (sel_idx == IW'(i));

    if (i == 0) begin : g_first
      assign left_v = cmd.data;
    end else begin : g_mid
      assign left_v = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = front_val;
    end else begin : g_inner
      assign right_v = cell_val[i+1];
    end

    olr_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .sel       (sel[i]),
      .left_val  (left_v),
      .right_val (right_v),
      .front_val (front_val),
      .val       (cell_val[i])
    );
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.element     = out_elem_r;
  assign out_ch.match_count = out_count_r;
  assign out_ch.last        = out_last_r;

  `OLR_ASSERT_ALWAYS(a_occ_bound, occ_r <= OW'(CAPACITY), "occupancy above capacity")
  `OLR_ASSERT_SAME(a_list_nonempty, state_r == S_LIST, occ_r != '0, "list walk on empty list")
  `OLR_ASSERT_SAME(a_walk_steps, state_r == S_LIST || state_r == S_REMOVE, steps_r != '0, "walk without steps")
  `OLR_ASSERT_NEXT(a_report_done, state_r == S_REPORT && slot_free, state_r == S_IDLE && out_valid_r, "removal report not issued")

endmodule

// ===== design/olr_cell.sv =====
// ----------------------------------------------------------------------------
// olr_cell
// One list position: holds one value and takes its next value from itself,
// a neighbor, the front cell or the broadcast data, as the command selects.
// ----------------------------------------------------------------------------
module olr_cell (
  input  logic                          clk,
  input  olr_pkg::cell_cmd_t            cmd,
  input  logic                          sel,
  input  logic [olr_pkg::DataW-1:0]     left_val,
  input  logic [olr_pkg::DataW-1:0]     right_val,
  input  logic [olr_pkg::DataW-1:0]     front_val,
  output logic [olr_pkg::DataW-1:0]     val
);

  logic [olr_pkg::DataW-1:0] val_r;
  logic [olr_pkg::DataW-1:0] val_nxt;

  always_comb begin
    case (cmd.mode)
      olr_pkg::M_HOLD: val_nxt = val_r;
      olr_pkg::M_SHR:  val_nxt = left_val;
      olr_pkg::M_ROT:  val_nxt = sel ? front_val : right_val;
      olr_pkg::M_DROP: val_nxt = right_val;
      olr_pkg::M_LOAD: val_nxt = sel ? cmd.data : val_r;
      default:         val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule
